>>> hw/rtl/lcgr_pkg.sv
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared types and constants for the 64-bit LCG with range queries:
// generator constants, command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgr_pkg;

  // Generator constants (multiplier and increment, modulo 2^64)
  localparam logic [63:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LCG_ADD = 64'h1405_7B7E_F767_814F;

  // Modulus of the percentage test, at divisor width
  localparam int          DIV_W        = 33;
  localparam logic [DIV_W-1:0] CHANCE_SCALE = 33'd10000;

  // Restoring divider: one dividend bit per cycle
  localparam int          DIV_ITER  = 64;
  localparam int          DIV_CNT_W = $clog2(DIV_ITER);

  // Stream payload widths (whole bytes)
  localparam int          IN_TDATA_W  = 80;
  localparam int          OUT_TDATA_W = 104;

  // Command codes
  typedef enum logic [1:0] {
    CMD_RAW    = 2'd0,
    CMD_CHANCE = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  // Partial product selection of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_LL = 2'd0,
    MS_LH = 2'd1,
    MS_HL = 2'd2
  } mul_sel_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MUL_LL = 3'd1,
    ST_MUL_LH = 3'd2,
    ST_MUL_HL = 3'd3,
    ST_UPD    = 3'd4,
    ST_DIV    = 3'd5,
    ST_FIN    = 3'd6
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_cfg;
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd;
    logic     div_step;
    logic     load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcgr_ctrl.sv
// ----------------------------------------------------------------------------
// lcgr_ctrl
// Sequencer: accepts configuration writes and items while idle, walks the
// three partial products, the state update, for chance and range the remainder
// iterations, and the hand-off into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire lcgr_pkg::dp_sts_t sts,
  output lcgr_pkg::dp_cmd_t     cmd
);

  lcgr_pkg::state_t state_r;
  lcgr_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcgr_pkg::ST_IDLE: begin
        if (in_tvalid && !cfg_valid) state_nxt = lcgr_pkg::ST_MUL_LL;
      end
      lcgr_pkg::ST_MUL_LL: state_nxt = lcgr_pkg::ST_MUL_LH;
      lcgr_pkg::ST_MUL_LH: state_nxt = lcgr_pkg::ST_MUL_HL;
      lcgr_pkg::ST_MUL_HL: state_nxt = lcgr_pkg::ST_UPD;
      lcgr_pkg::ST_UPD: begin
        state_nxt = sts.need_div ? lcgr_pkg::ST_DIV : lcgr_pkg::ST_FIN;
      end
      lcgr_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = lcgr_pkg::ST_FIN;
      end
      lcgr_pkg::ST_FIN: begin
        if (sts.out_free) state_nxt = lcgr_pkg::ST_IDLE;
      end
      default: state_nxt = lcgr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.mul_sel = lcgr_pkg::MS_LL;
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      lcgr_pkg::ST_IDLE: begin
        // hold off both channels in reset; configuration wins over a waiting item
        cfg_ready    = rst_n;
        in_tready    = rst_n && !cfg_valid;
        cmd.load_cfg = rst_n && cfg_valid;
        cmd.load_in  = rst_n && in_tvalid && !cfg_valid;
      end
      lcgr_pkg::ST_MUL_LL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lcgr_pkg::MS_LL;
      end
      lcgr_pkg::ST_MUL_LH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lcgr_pkg::MS_LH;
      end
      lcgr_pkg::ST_MUL_HL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lcgr_pkg::MS_HL;
      end
      lcgr_pkg::ST_UPD: cmd.upd = 1'b1;
      lcgr_pkg::ST_DIV: cmd.div_step = 1'b1;
      lcgr_pkg::ST_FIN: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcgr_dp.sv
// ----------------------------------------------------------------------------
// lcgr_dp
// Datapath: generator state, shared 32x32 multiplier, bound ordering and
// span, restoring remainder unit, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgr_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lcgr_pkg::dp_cmd_t      cmd,
  output lcgr_pkg::dp_sts_t           sts,
  input  wire logic [63:0]            cfg_data,
  input  wire logic [1:0]             command,
  input  wire logic [13:0]            chance_hundredths,
  input  wire logic signed [31:0]     bound_a,
  input  wire logic signed [31:0]     bound_b,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [lcgr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [63:0]                  state_r;
  lcgr_pkg::cmd_t               cmd_r;
  logic [13:0]                  pct_r;
  logic signed [31:0]           lo_r;
  logic [lcgr_pkg::DIV_W-1:0]   div_r;
  logic [63:0]                  p0_r;
  logic [31:0]                  cross_r;
  logic [63:0]                  quo_r;
  logic [31:0]                  rem_r;
  logic [lcgr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                         out_valid_r;
  logic [lcgr_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [31:0]                  mul_a;
  logic [31:0]                  mul_b;
  logic [63:0]                  prod;
  logic [63:0]                  state_nxt;
  logic                         a_gt_b;
  logic signed [31:0]           lo_sel;
  logic signed [31:0]           hi_sel;
  logic [lcgr_pkg::DIV_W-1:0]   span;
  logic [lcgr_pkg::DIV_W-1:0]   trial;
  logic                         hit;
  logic [31:0]                  ranged;

  // Order the bounds and form the span in 33 bits
  always_comb begin
    a_gt_b = bound_a > bound_b;
    lo_sel = a_gt_b ? bound_b : bound_a;
    hi_sel = a_gt_b ? bound_a : bound_b;
    span   = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel} + 33'd1;
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= lcgr_pkg::cmd_t'(command);
      pct_r <= chance_hundredths;
      lo_r  <= lo_sel;
      div_r <= (command == lcgr_pkg::CMD_CHANCE) ? lcgr_pkg::CHANCE_SCALE : span;
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      lcgr_pkg::MS_LL: begin
        mul_a = state_r[31:0];
        mul_b = lcgr_pkg::LCG_MUL[31:0];
      end
      lcgr_pkg::MS_LH: begin
        mul_a = state_r[31:0];
        mul_b = lcgr_pkg::LCG_MUL[63:32];
      end
      lcgr_pkg::MS_HL: begin
        mul_a = state_r[63:32];
        mul_b = lcgr_pkg::LCG_MUL[31:0];
      end
      default: begin
        mul_a = state_r[31:0];
        mul_b = lcgr_pkg::LCG_MUL[31:0];
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Collect partial products; cross terms only matter modulo 2^32
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        lcgr_pkg::MS_LL: p0_r <= prod;
        lcgr_pkg::MS_LH: cross_r <= prod[31:0];
        lcgr_pkg::MS_HL: cross_r <= cross_r + prod[31:0];
        default: ;
      endcase
    end
  end

  assign state_nxt = p0_r + {cross_r, 32'd0} + lcgr_pkg::LCG_ADD;

  // Generator state: seed write or advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 64'd1;
    end else if (cmd.load_cfg) begin
      state_r <= (cfg_data == 64'd0) ? 64'd1 : cfg_data;
    end else if (cmd.upd) begin
      state_r <= state_nxt;
    end
  end

  // Restoring remainder: shift in one dividend bit per cycle
  assign trial = {rem_r, quo_r[63]};

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      quo_r <= state_nxt;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[62:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (trial >= div_r) begin
        rem_r <= 32'(trial - div_r);
      end else begin
        rem_r <= trial[31:0];
      end
    end
  end

  // Result fields
  always_comb begin
    hit    = (cmd_r == lcgr_pkg::CMD_CHANCE) && ({2'b00, rem_r} < {20'd0, pct_r});
    ranged = (cmd_r == lcgr_pkg::CMD_RANGE) ? 32'(lo_r + $signed(rem_r)) : 32'd0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'd0, ranged, hit, state_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  // Status
  assign sts.need_div = (cmd_r == lcgr_pkg::CMD_CHANCE) || (cmd_r == lcgr_pkg::CMD_RANGE);
  assign sts.div_last = cnt_r == lcgr_pkg::DIV_CNT_W'(lcgr_pkg::DIV_ITER - 1);
  assign sts.out_free = !out_valid_r || out_tready;

  // A zero seed loads one
  a_zero_seed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_cfg && (cfg_data == 64'd0) |=> state_r == 64'd1)
    else $error("zero seed did not load one");

  // Partial remainder stays below the divisor during iterations
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ({1'b0, rem_r} < div_r))
    else $error("partial remainder not below divisor");

  // A loaded result is presented next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  // Output is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

>>> hw/rtl/lcg64_random_with_range.sv
// Sequence: an accepted item takes three passes through one shared 32x32
//   multiplier and the state update, then, for the chance and range commands
//   only, a restoring remainder unit; the result is then registered. A new
//   item is taken only once the last result has been handed off.
// Reset (rst_n low, synchronous): generator state 1, controller idle, no result.
// ----------------------------------------------------------------------------
// lcg64_random_with_range
// 64-bit linear congruential generator with raw, percentage-test and
// bounded-integer queries; seed loaded through a separate write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg64_random_with_range (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // seed write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,
  // item in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[1:0], chance_hundredths[15:2], bound_a[47:16], bound_b[79:48]
  input  wire logic [lcgr_pkg::IN_TDATA_W-1:0] in_tdata,
  // result out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // raw_value[63:0], chance_hit[64], ranged_value[96:65], zero fill [103:97]
  output logic [lcgr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lcgr_pkg::dp_cmd_t dp_cmd;
  lcgr_pkg::dp_sts_t dp_sts;

  // Sequencer
  lcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // Datapath, fields unpacked from the input item
  lcgr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .cfg_data          (cfg_data),
    .command           (in_tdata[1:0]),
    .chance_hundredths (in_tdata[15:2]),
    .bound_a           ($signed(in_tdata[47:16])),
    .bound_b           ($signed(in_tdata[79:48])),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata)
  );

endmodule

`default_nettype wire
